// File: src/mopt_pkg.sv
// shared types, constants and helpers of the map/odometry pose transform
// depends on nothing; used by mopt_cordic and map_odom_pose_transform_core
package mopt_pkg;

	localparam int CW = 34;
	localparam int PW = 2 * CW;
	localparam int CORDIC_STEPS = 30;
	localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;

	typedef struct packed {
		logic               command;
		logic signed [31:0] odom_x;
		logic signed [31:0] odom_y;
		logic signed [15:0] odom_heading;
		logic signed [31:0] corr_dx;
		logic signed [31:0] corr_dy;
		logic signed [15:0] corr_dheading;
		logic        [15:0] corr_weight;
	} req_t;

	typedef struct packed {
		logic signed [31:0] map_x;
		logic signed [31:0] map_y;
		logic signed [15:0] map_heading;
	} rsp_t;

	typedef struct packed {
		logic                 done;
		logic signed [CW-1:0] cos_v;
		logic signed [CW-1:0] sin_v;
	} cordic_res_t;

	function automatic logic signed [CW-1:0] turn_atan(input logic [4:0] i);
		logic signed [CW-1:0] r;
		case (i)
			5'd0: r = 34'sd536870912;
			5'd1: r = 34'sd316933406;
			5'd2: r = 34'sd167458907;
			5'd3: r = 34'sd85004756;
			5'd4: r = 34'sd42667331;
			5'd5: r = 34'sd21354465;
			5'd6: r = 34'sd10679838;
			5'd7: r = 34'sd5340245;
			5'd8: r = 34'sd2670163;
			5'd9: r = 34'sd1335087;
			5'd10: r = 34'sd667544;
			5'd11: r = 34'sd333772;
			5'd12: r = 34'sd166886;
			5'd13: r = 34'sd83443;
			5'd14: r = 34'sd41722;
			5'd15: r = 34'sd20861;
			5'd16: r = 34'sd10430;
			5'd17: r = 34'sd5215;
			5'd18: r = 34'sd2608;
			5'd19: r = 34'sd1304;
			5'd20: r = 34'sd652;
			5'd21: r = 34'sd326;
			5'd22: r = 34'sd163;
			5'd23: r = 34'sd81;
			5'd24: r = 34'sd41;
			5'd25: r = 34'sd20;
			5'd26: r = 34'sd10;
			5'd27: r = 34'sd5;
			5'd28: r = 34'sd3;
			5'd29: r = 34'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -36'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// File: src/mopt_cordic.sv
// iterative cordic: cosine and sine of a binary angle, one micro-rotation a cycle
// depends on mopt_pkg
module mopt_cordic #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [ANGLE_BITS-1:0]   angle,
	output mopt_pkg::cordic_res_t   res
);
	import mopt_pkg::*;

	typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIX} cstate_t;

	cstate_t              state_q;
	logic signed [CW-1:0] x_q, y_q, z_q;
	logic        [4:0]    step_q;
	logic                 flip_q;
	logic                 done_q;
	logic signed [CW-1:0] cos_q, sin_q;

	logic        [31:0]   a32;
	logic signed [31:0]   z_raw;
	logic                 fold;
	logic        [31:0]   z0;
	logic signed [CW-1:0] xs, ys;

	// turn angle in 32 bits, folded into the right half plane
	assign a32   = 32'(angle) << (32 - ANGLE_BITS);
	assign z_raw = $signed(a32);
	assign fold  = (z_raw > 32'sd1073741824) || (z_raw < -32'sd1073741824);
	assign z0    = fold ? {~a32[31], a32[30:0]} : a32;
	assign xs    = x_q >>> step_q;
	assign ys    = y_q >>> step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (start) begin
						x_q     <= CORDIC_K;
						y_q     <= '0;
						z_q     <= CW'($signed(z0));
						flip_q  <= fold;
						step_q  <= '0;
						state_q <= C_RUN;
					end
				end
				C_RUN: begin
					if (!z_q[CW-1]) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - turn_atan(step_q);
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + turn_atan(step_q);
					end
					step_q <= step_q + 5'd1;
					if (step_q == 5'(CORDIC_STEPS - 1)) begin
						state_q <= C_FIX;
					end
				end
				C_FIX: begin
					cos_q   <= flip_q ? -x_q : x_q;
					sin_q   <= flip_q ? -y_q : y_q;
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign res.done  = done_q;
	assign res.cos_v = cos_q;
	assign res.sin_v = sin_q;

`ifndef ASSERT_OFF
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(start && state_q == C_IDLE) |=> (state_q == C_RUN))
		else $error("cordic did not start");
	a_done_after_fix: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == C_FIX))
		else $error("cordic done without final step");
	a_step_zero_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == C_FIX) |-> (step_q == 5'(CORDIC_STEPS)))
		else $error("cordic step count off");
`endif

endmodule

// File: src/map_odom_pose_transform_core.sv
// map/odometry pose transform: apply offset or update offset from a weighted correction
// one request at a time: req_stall stays high from acceptance until the result is written,
// which waits in S_MAP while a held result is stalled; both commands use the 30-step cordic
// and the single shared multiplier
// a finished result waits in the output register while the next request is taken
// reset (arst_n low, asynchronous): offset cleared, last map pose 5.0, 5.0, minus a quarter turn
module map_odom_pose_transform_core #(
	parameter int FRAC_BITS  = 16,
	parameter int ANGLE_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  mopt_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output mopt_pkg::rsp_t  rsp
);
	import mopt_pkg::*;

	localparam int AW = ANGLE_BITS;
	localparam int HW = (AW > 16) ? AW : 16;

	typedef enum logic [3:0] {
		S_IDLE, S_SX, S_SY, S_SH, S_SOLVE, S_CINIT, S_CORD,
		S_M0, S_M1, S_M2, S_M3, S_M4, S_OFF, S_MAP
	} state_t;

	state_t               state_q;
	req_t                 req_q;
	// transform state
	logic signed [31:0]   off_x_q, off_y_q;
	logic        [AW-1:0] off_h_q;
	logic signed [31:0]   lm_x_q, lm_y_q;
	logic        [AW-1:0] lm_h_q;
	// working registers
	logic signed [31:0]   tx_q, ty_q;
	logic signed [PW-1:0] prod_q, acc_q;
	logic signed [CW-1:0] rx_q, ry_q;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;

	logic signed [CW-1:0] mul_a, mul_b;
	logic        [15:0]   w_sat;
	logic signed [CW-1:0] w_cw;
	logic        [HW-1:0] oh_ext, dh_ext;
	logic        [AW-1:0] oh, dh;
	logic signed [CW-1:0] dh_cw;
	logic signed [PW-1:0] share_v;
	logic signed [PW-1:0] half;
	logic signed [PW-1:0] rx_full, ry_full;
	logic        [AW-1:0] th;
	logic signed [31:0]   map_x_n, map_y_n;
	logic        [AW-1:0] map_h_n;
	logic                 cstart;
	cordic_res_t          cres;

	// headings: low angle bits of the field, taken as a wrapping binary angle
	assign oh_ext = HW'($unsigned(req_q.odom_heading));
	assign dh_ext = HW'($unsigned(req_q.corr_dheading));
	assign oh     = oh_ext[AW-1:0];
	assign dh     = dh_ext[AW-1:0];
	assign dh_cw  = CW'($signed(dh));

	// weight above one saturates to one
	assign w_sat = (req_q.corr_weight > 16'd32768) ? 16'd32768 : req_q.corr_weight;
	assign w_cw  = $signed({{(CW-16){1'b0}}, w_sat});

	// operand select of the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SX: begin
				mul_a = CW'(req_q.corr_dx);
				mul_b = w_cw;
			end
			S_SY: begin
				mul_a = CW'(req_q.corr_dy);
				mul_b = w_cw;
			end
			S_SH: begin
				mul_a = dh_cw;
				mul_b = w_cw;
			end
			S_M0: begin
				mul_a = cres.cos_v;
				mul_b = CW'(req_q.odom_x);
			end
			S_M1: begin
				mul_a = cres.sin_v;
				mul_b = CW'(req_q.odom_y);
			end
			S_M2: begin
				mul_a = cres.sin_v;
				mul_b = CW'(req_q.odom_x);
			end
			S_M3: begin
				mul_a = cres.cos_v;
				mul_b = CW'(req_q.odom_y);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// rounded weighted share and rounded rotation sums
	assign share_v = (prod_q + PW'(16384)) >>> 15;
	assign half    = {{(PW-30){1'b0}}, 1'b1, 29'b0};
	assign rx_full = (acc_q - prod_q + half) >>> 30;
	assign ry_full = (acc_q + prod_q + half) >>> 30;
	assign th      = lm_h_q + share_v[AW-1:0];

	assign map_x_n = sat32(36'(rx_q) + 36'(off_x_q));
	assign map_y_n = sat32(36'(ry_q) + 36'(off_y_q));
	assign map_h_n = oh + off_h_q;

	assign cstart = (state_q == S_CINIT);

	mopt_cordic #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cstart),
		.angle  (off_h_q),
		.res    (cres)
	);

	// shared multiplier, product registered every cycle
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			off_x_q     <= '0;
			off_y_q     <= '0;
			off_h_q     <= '0;
			lm_x_q      <= 32'(5) << FRAC_BITS;
			lm_y_q      <= 32'(5) << FRAC_BITS;
			lm_h_q      <= {2'b11, {(AW-2){1'b0}}};
		end else begin
			// the final step reloads the output register itself
			if (rsp_valid_q && !rsp_stall && state_q != S_MAP) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						state_q <= req.command ? S_SX : S_CINIT;
					end
				end
				S_SX: state_q <= S_SY;
				S_SY: begin
					tx_q    <= sat32(36'(lm_x_q) + 36'($signed(share_v[32:0])));
					state_q <= S_SH;
				end
				S_SH: begin
					ty_q    <= sat32(36'(lm_y_q) + 36'($signed(share_v[32:0])));
					state_q <= S_SOLVE;
				end
				S_SOLVE: begin
					// new offset heading from the target heading
					off_h_q <= th - oh;
					state_q <= S_CINIT;
				end
				S_CINIT: state_q <= S_CORD;
				S_CORD: begin
					if (cres.done) begin
						state_q <= S_M0;
					end
				end
				S_M0: state_q <= S_M1;
				S_M1: begin
					acc_q   <= prod_q;
					state_q <= S_M2;
				end
				S_M2: begin
					rx_q    <= rx_full[CW-1:0];
					state_q <= S_M3;
				end
				S_M3: begin
					acc_q   <= prod_q;
					state_q <= S_M4;
				end
				S_M4: begin
					ry_q    <= ry_full[CW-1:0];
					state_q <= S_OFF;
				end
				S_OFF: begin
					if (req_q.command) begin
						off_x_q <= sat32(36'(tx_q) - 36'(rx_q));
						off_y_q <= sat32(36'(ty_q) - 36'(ry_q));
					end
					state_q <= S_MAP;
				end
				S_MAP: begin
					// wait for the output register to free up
					if (!rsp_valid_q || !rsp_stall) begin
						lm_x_q            <= map_x_n;
						lm_y_q            <= map_y_n;
						lm_h_q            <= map_h_n;
						rsp_q.map_x       <= map_x_n;
						rsp_q.map_y       <= map_y_n;
						rsp_q.map_heading <= 16'(map_h_n);
						rsp_valid_q       <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken while idle after accept");
	a_rsp_from_map: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == S_MAP))
		else $error("result raised outside final step");
	a_cordic_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		cres.done |-> (state_q == S_CORD))
		else $error("cordic finished while not awaited");
	a_cordic_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CINIT) |=> (state_q == S_CORD))
		else $error("cordic start not followed by wait");
`endif

endmodule
